// File: design/jfp_pkg.sv
// shared types and constants of the position jitter buffer
package jfp_pkg;

    localparam int CNT_W    = 7;
    localparam int COORD_W  = 32;
    localparam int STAMP_W  = 48;
    localparam int LAT_W    = 12;
    localparam int HEALTH_W = 7;

    localparam int LAT_PER_ENTRY = 50;
    localparam int PCT_SCALE     = 100;

    localparam logic [CNT_W-1:0] CAP_RESET     = 7'd64;
    localparam logic [CNT_W-1:0] MIN_FILL_RESET = 7'd1;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_PLAY  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MIN_FILL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUFFERING = 2'd1,
        ST_UNDERRUN  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [STAMP_W-1:0]        stamp;
    } t_entry;

endpackage

// File: design/jitter_fifo_playback.sv
// position jitter buffer: ring memory with add, play and flush commands
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  command  | start, busy               | i_cmd, i_x_pos, i_y_pos, i_stamp
//  result   | o_done (one-cycle strobe) | o_out_x, o_out_y, o_out_stamp, o_status,
//           |                           | o_ready_res, o_fill, o_latency_ms, o_health_pct
//  config   | i_cfg_we                  | i_cfg_addr, i_cfg_data
//
// an item is taken when start is high and busy low; busy then stays high through one ring
// update and the steps of the health divider at two quotient bits per cycle, and o_done pulses
// in the cycle busy falls; a new item is taken only once busy is low again
// the ring read is registered, issued at the accept edge from the head pointer
// synchronous active-low reset clears pointers, fill, start flag and config registers;
// the ring contents are not cleared
// results cannot be held off by the receiver
module jitter_fifo_playback #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_cmd,
    input  logic signed [jfp_pkg::COORD_W-1:0]  i_x_pos,
    input  logic signed [jfp_pkg::COORD_W-1:0]  i_y_pos,
    input  logic [jfp_pkg::STAMP_W-1:0]         i_stamp,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [jfp_pkg::CNT_W-1:0]           i_cfg_data,
    output logic                                o_done,
    output logic signed [jfp_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [jfp_pkg::COORD_W-1:0]  o_out_y,
    output logic [jfp_pkg::STAMP_W-1:0]         o_out_stamp,
    output logic [1:0]                          o_status,
    output logic                                o_ready_res,
    output logic [jfp_pkg::CNT_W-1:0]           o_fill,
    output logic [jfp_pkg::LAT_W-1:0]           o_latency_ms,
    output logic [jfp_pkg::HEALTH_W-1:0]        o_health_pct
);
    import jfp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam int DVD_W = 2 * (CNT_W + 1);
    localparam int DIV_STEPS = (CNT_W + 1) / 2;
    localparam int STEP_W = $clog2(DIV_STEPS);

    // ring memory
    t_entry r_mem [DEPTH];
    t_entry r_rd;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step;

    logic [CNT_W-1:0] r_capacity, r_min_fill;
    logic [PW-1:0]    r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_started, n_started;

    logic [1:0]                 r_cmd;
    t_entry                     r_in;

    t_entry                     r_out;
    t_status                    r_status, n_status;
    logic                       r_ready, r_done;
    logic [LAT_W-1:0]           r_lat;
    logic [HEALTH_W-1:0]        r_health;
    logic                       r_full;

    // divider state
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W:0]   r_low, n_low;
    logic [CNT_W:0]   r_quo, n_quo;
    logic [DVD_W-1:0] w_dvd;

    logic [CNT_W-1:0] w_cap, w_minf;
    logic             w_take, w_exec, w_div, w_last, w_we, w_play_ok;

    // effective capacity and min fill
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CNT_W'(1);
        end else if (32'(r_capacity) > DEPTH) begin
            w_cap = CNT_W'(DEPTH);
        end else begin
            w_cap = r_capacity;
        end
        w_minf = (r_min_fill == '0) ? CNT_W'(1) : r_min_fill;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_EXEC;
            S_EXEC: n_state = S_DIV;
            S_DIV:  if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy   = (r_state != S_IDLE);
        w_take = (r_state == S_IDLE) && start;
        w_exec = (r_state == S_EXEC);
        w_div  = (r_state == S_DIV);
        w_last = w_div && (r_step == STEP_W'(DIV_STEPS - 1));
    end

    // ring update for the latched command
    always_comb begin
        logic [CNT_W-1:0] drop;
        logic [CNT_W-1:0] kept;
        logic [SW-1:0]    sum;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_started = r_started;
        n_status  = ST_OK;
        w_we      = 1'b0;
        w_play_ok = 1'b0;
        drop      = '0;
        kept      = r_count;
        sum       = '0;
        unique case (r_cmd)
            CMD_ADD: begin
                // full ring: drop oldest entries so the add lands at capacity
                if (r_count >= w_cap) begin
                    drop = r_count - w_cap + CNT_W'(1);
                    kept = w_cap - CNT_W'(1);
                    sum  = SW'(r_head) + SW'(drop);
                    n_head = (sum >= SW'(DEPTH)) ? PW'(sum - SW'(DEPTH)) : PW'(sum);
                end
                w_we      = 1'b1;
                n_tail    = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + PW'(1);
                n_count   = kept + CNT_W'(1);
                n_started = r_started || (n_count >= w_minf);
            end
            CMD_PLAY: begin
                if (!r_started) begin
                    n_status = ST_BUFFERING;
                end else if (r_count == '0) begin
                    n_status = ST_UNDERRUN;
                end else begin
                    w_play_ok = 1'b1;
                    n_head  = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_FLUSH: begin
                n_head    = '0;
                n_tail    = '0;
                n_count   = '0;
                n_started = 1'b0;
            end
            default: ;
        endcase
        w_dvd = DVD_W'(n_count) * DVD_W'(PCT_SCALE);
    end

    // two restoring division steps per cycle
    always_comb begin
        logic [CNT_W:0] trial;
        logic [CNT_W-1:0] rem;
        logic [CNT_W:0] low;
        logic [CNT_W:0] quo;
        rem = r_rem;
        low = r_low;
        quo = r_quo;
        for (int i = 0; i < 2; i++) begin
            trial = {rem, low[CNT_W]};
            low   = {low[CNT_W-1:0], 1'b0};
            if (trial >= {1'b0, w_cap}) begin
                rem = CNT_W'(trial - {1'b0, w_cap});
                quo = {quo[CNT_W-1:0], 1'b1};
            end else begin
                rem = CNT_W'(trial);
                quo = {quo[CNT_W-1:0], 1'b0};
            end
        end
        n_rem = rem;
        n_low = low;
        n_quo = quo;
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (w_exec && w_we) begin
            r_mem[r_tail] <= r_in;
        end
        r_rd <= r_mem[r_head];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_capacity <= CAP_RESET;
            r_min_fill <= MIN_FILL_RESET;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_started  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_last;
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_CAPACITY) r_capacity <= i_cfg_data;
                if (i_cfg_addr == REG_MIN_FILL) r_min_fill <= i_cfg_data;
            end
            if (w_exec) begin
                r_step    <= '0;
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_count   <= n_count;
                r_started <= n_started;
            end else if (w_div) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd      <= i_cmd;
            r_in.x     <= i_x_pos;
            r_in.y     <= i_y_pos;
            r_in.stamp <= i_stamp;
        end
        if (w_exec) begin
            r_out    <= w_play_ok ? r_rd : '0;
            r_status <= n_status;
            r_ready  <= n_started || (n_count >= w_minf);
            r_full   <= (n_count >= w_cap);
            // quotient < 256 if fill <= capacity, so the high half is below the divisor
            r_rem    <= w_dvd[DVD_W-2 -: CNT_W];
            r_low    <= w_dvd[CNT_W:0];
            r_quo    <= '0;
        end
        if (w_div) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_quo <= n_quo;
        end
        if (w_last) begin
            r_health <= r_full ? HEALTH_W'(PCT_SCALE) : HEALTH_W'(n_quo);
            r_lat    <= r_started ?
                        LAT_W'((LAT_W + 1)'(r_count) * (LAT_W + 1)'(LAT_PER_ENTRY)) : '0;
        end
    end

    assign o_done       = r_done;
    assign o_out_x      = r_out.x;
    assign o_out_y      = r_out.y;
    assign o_out_stamp  = r_out.stamp;
    assign o_status     = r_status;
    assign o_ready_res  = r_ready;
    assign o_fill       = r_count;
    assign o_latency_ms = r_lat;
    assign o_health_pct = r_health;

    // an accepted item always occupies the block
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> busy)
        else $error("accepted item did not raise busy");

    // ring pointers stay consistent with the fill
    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) <= DEPTH) &&
        (((SW'(r_head) + SW'(r_count)) >= SW'(DEPTH)) ?
            (PW'(SW'(r_head) + SW'(r_count) - SW'(DEPTH)) == r_tail) :
            (PW'(SW'(r_head) + SW'(r_count)) == r_tail)))
        else $error("head, tail and fill disagree");

    // a failed result carries no entry (non-play results carry none either, unchecked)
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |->
            ((o_out_x == '0) && (o_out_y == '0) && (o_out_stamp == '0)))
        else $error("payload set on a result without a played entry");

    // health never exceeds full scale
    a_health_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_health_pct <= HEALTH_W'(PCT_SCALE)))
        else $error("health above full scale");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the position jitter buffer: directed and random commands
module tb;
    import jfp_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [STAMP_W-1:0]        stamp;
        t_status                   status;
        logic                      ready;
        logic [CNT_W-1:0]          fill;
        logic [LAT_W-1:0]          latency;
        logic [HEALTH_W-1:0]       health;
    } t_report;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  i_cmd = CMD_ADD;
    logic signed [COORD_W-1:0]   i_x_pos = '0;
    logic signed [COORD_W-1:0]   i_y_pos = '0;
    logic [STAMP_W-1:0]          i_stamp = '0;
    logic                        i_cfg_we = 1'b0;
    logic                        i_cfg_addr = REG_CAPACITY;
    logic [CNT_W-1:0]            i_cfg_data = '0;
    logic                        o_done;
    logic signed [COORD_W-1:0]   o_out_x;
    logic signed [COORD_W-1:0]   o_out_y;
    logic [STAMP_W-1:0]          o_out_stamp;
    logic [1:0]                  o_status;
    logic                        o_ready_res;
    logic [CNT_W-1:0]            o_fill;
    logic [LAT_W-1:0]            o_latency_ms;
    logic [HEALTH_W-1:0]         o_health_pct;

    jitter_fifo_playback #(.DEPTH(DEPTH)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_stamp      (i_stamp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_stamp  (o_out_stamp),
        .o_status     (o_status),
        .o_ready_res  (o_ready_res),
        .o_fill       (o_fill),
        .o_latency_ms (o_latency_ms),
        .o_health_pct (o_health_pct)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted buffer state
    t_entry           ring_mem [DEPTH];
    int               head_idx = 0;
    int               tail_idx = 0;
    int               held = 0;
    bit               playing = 1'b0;
    logic [CNT_W-1:0] cap_reg = CAP_RESET;
    logic [CNT_W-1:0] minf_reg = MIN_FILL_RESET;

    t_report queued_reports [$];
    bit      gaps_on = 1'b1;
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_adds = 0;
    int      n_plays = 0;
    int      n_flushes = 0;
    int      n_underruns = 0;
    int      n_buffering = 0;
    int      n_phases = 0;

    function automatic t_report buffer_step(input logic [1:0] cmd, input t_entry e);
        t_report r;
        int cap;
        int minf;
        int drop;
        int pct;
        cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        minf = (minf_reg == 0) ? 1 : int'(minf_reg);
        r.x = '0;
        r.y = '0;
        r.stamp = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ADD: begin
                // a full ring, or one whose capacity was lowered, loses its oldest entries
                if (held >= cap) begin
                    drop = held - cap + 1;
                    head_idx = (head_idx + drop) % DEPTH;
                    held -= drop;
                end
                ring_mem[tail_idx] = e;
                tail_idx = (tail_idx + 1) % DEPTH;
                held++;
                if (!playing && held >= minf) playing = 1'b1;
            end
            CMD_PLAY: begin
                if (!playing) begin
                    r.status = ST_BUFFERING;
                end else if (held == 0) begin
                    r.status = ST_UNDERRUN;
                end else begin
                    r.x = ring_mem[head_idx].x;
                    r.y = ring_mem[head_idx].y;
                    r.stamp = ring_mem[head_idx].stamp;
                    head_idx = (head_idx + 1) % DEPTH;
                    held--;
                end
            end
            CMD_FLUSH: begin
                head_idx = 0;
                tail_idx = 0;
                held = 0;
                playing = 1'b0;
            end
            default: ;
        endcase
        pct = held * PCT_SCALE / cap;
        if (pct > PCT_SCALE) pct = PCT_SCALE;
        r.ready = playing || held >= minf;
        r.fill = CNT_W'(held);
        r.latency = playing ? LAT_W'(held * LAT_PER_ENTRY) : '0;
        r.health = HEALTH_W'(pct);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_report want;
        if (i_rst_n && o_done === 1'b1) begin
            if (queued_reports.size() == 0) begin
                $error("result with no item outstanding");
                n_errors++;
            end else begin
                want = queued_reports.pop_front();
                check_field("out_x", want.x, o_out_x);
                check_field("out_y", want.y, o_out_y);
                check_field("out_stamp", want.stamp, o_out_stamp);
                check_field("status", want.status, o_status);
                check_field("ready_res", want.ready, o_ready_res);
                check_field("fill", want.fill, o_fill);
                check_field("latency_ms", want.latency, o_latency_ms);
                check_field("health_pct", want.health, o_health_pct);
                n_checked++;
            end
        end
    end

    function automatic t_entry random_entry();
        t_entry e;
        e.x = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000)
                                          : $urandom;
        e.y = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000)
                                          : $urandom;
        e.stamp = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                              : {16'($urandom), 32'($urandom)};
        return e;
    endfunction

    // start stays high from one item to the next when there is no gap
    task automatic send_item(input logic [1:0] cmd, input t_entry e);
        t_report want;
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_x_pos <= e.x;
        i_y_pos <= e.y;
        i_stamp <= e.stamp;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = buffer_step(cmd, e);
        queued_reports.push_back(want);
        case (cmd)
            CMD_ADD:   n_adds++;
            CMD_PLAY:  n_plays++;
            CMD_FLUSH: n_flushes++;
            default: ;
        endcase
        if (want.status == ST_UNDERRUN) n_underruns++;
        if (want.status == ST_BUFFERING) n_buffering++;
    endtask

    task automatic send_cmd(input logic [1:0] cmd);
        send_item(cmd, random_entry());
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (queued_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_CAPACITY) cap_reg = val;
        else minf_reg = val;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        t_entry e;
        send_cmd(CMD_PLAY);
        send_cmd(CMD_UNUSED);
        e.x = 32'sh7fffffff;
        e.y = 32'sh80000000;
        e.stamp = '1;
        send_item(CMD_ADD, e);
        e.x = 32'sh80000000;
        e.y = 32'sh7fffffff;
        e.stamp = '0;
        send_item(CMD_ADD, e);
        send_cmd(CMD_PLAY);
        send_cmd(CMD_PLAY);
        send_cmd(CMD_PLAY);
        send_cmd(CMD_ADD);
        send_cmd(CMD_FLUSH);
        send_cmd(CMD_PLAY);
    endtask

    // zero capacity and zero minimum behave as one
    task automatic test_zero_registers();
        wait_idle();
        write_reg(REG_CAPACITY, 7'd0);
        write_reg(REG_MIN_FILL, 7'd0);
        send_cmd(CMD_ADD);
        send_cmd(CMD_ADD);
        send_cmd(CMD_PLAY);
        send_cmd(CMD_PLAY);
    endtask

    // capacity lowered below the fill: health saturates, next add trims the ring
    task automatic test_shrink_capacity();
        wait_idle();
        write_reg(REG_CAPACITY, 7'd64);
        write_reg(REG_MIN_FILL, 7'd3);
        send_cmd(CMD_ADD);
        send_cmd(CMD_ADD);
        send_cmd(CMD_PLAY);
        repeat (3) send_cmd(CMD_ADD);
        wait_idle();
        write_reg(REG_CAPACITY, 7'd2);
        send_cmd(CMD_PLAY);
        send_cmd(CMD_ADD);
        send_cmd(CMD_PLAY);
    endtask

    // bursts of adds and plays so the ring fills, overflows and drains
    task automatic test_random_phase(input logic [CNT_W-1:0] cap, input logic [CNT_W-1:0] minf,
                                     input bit with_gaps);
        int sent;
        int pick;
        int len;
        logic [1:0] cmd;
        wait_idle();
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_MIN_FILL, minf);
        gaps_on = with_gaps;
        n_phases++;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
            if (pick == 0) begin
                cmd = CMD_FLUSH;
                len = 1;
            end else if (pick == 1) begin
                cmd = CMD_UNUSED;
                len = 1;
            end else if (pick < 11) begin
                cmd = CMD_ADD;
            end else begin
                cmd = CMD_PLAY;
            end
            repeat (len) begin
                if (sent < PHASE_ITEMS) begin
                    send_cmd(cmd);
                    sent++;
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_registers();
        test_shrink_capacity();
        test_random_phase(7'd64, 7'd1, 1'b1);
        test_random_phase(7'd1, 7'd1, 1'b0);
        test_random_phase(7'd127, 7'd64, 1'b1);
        test_random_phase(7'd0, 7'd0, 1'b1);
        test_random_phase(7'd64, 7'd64, 1'b1);
        test_random_phase(7'd8, 7'd3, 1'b0);
        test_random_phase(7'd2, 7'd127, 1'b1);
        test_random_phase(7'd33, 7'd16, 1'b1);
        repeat (3) test_random_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 1'b1);

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("ran %0d random register settings: %0d adds, %0d plays, %0d flushes",
                 n_phases, n_adds, n_plays, n_flushes);
        $display("%0d results compared, %0d underruns and %0d buffering replies among them",
                 n_checked, n_underruns, n_buffering);
        if (n_errors == 0 && queued_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
